@@ rtl/iim_pkg.sv @@
// iim_pkg: shared constants and types for the interval merge block.
// No dependencies.
`timescale 1ns / 1ps
package iim_pkg;
  localparam int STORE_DEPTH = 64;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int DW = 64;
  localparam int KW = DW + AW;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;
endpackage

@@ rtl/iim_store.sv @@
// iim_store: interval store, one write and one registered read per cycle.
// Depends on iim_pkg.
`timescale 1ns / 1ps
module iim_store (
  input  logic                   clk,
  input  iim_pkg::mem_req_t      req,
  output logic [iim_pkg::DW-1:0] rd_data
);
  logic [iim_pkg::DW-1:0] mem [iim_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

@@ rtl/interval_insert_merge.sv @@
// interval_insert_merge: top level, load control, selection scan and merge.
// Depends on iim_pkg and iim_store.
//
// Usage: intervals arrive on the in_ channel (valid/ready), one word per
// cycle while loading; in_final_item closes the set. Words beyond
// STORE_DEPTH are dropped and flagged on every result of that set.
// After the final word the block stops taking input and scans the store:
// each scan pass reads all n stored entries through one memory read
// port and picks the next entry in (start, end, slot) order, which is
// folded into the running merged interval. Results leave on the out_
// channel from an output register; out_run_last marks the last merged
// interval, after which loading resumes. A stalled receiver holds the
// scan; nothing is lost. Reset (rst_n low, synchronous) empties the
// store and clears the dropped flag; the store contents need no
// clearing.
`timescale 1ns / 1ps
module interval_insert_merge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_range_start,
  input  logic [31:0] in_range_end,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_merged_start,
  output logic [31:0] out_merged_end,
  output logic        out_run_last,
  output logic        out_overflow_seen
);
  localparam int AW = iim_pkg::AW;
  localparam int CW = iim_pkg::CW;
  localparam int DW = iim_pkg::DW;
  localparam int KW = iim_pkg::KW;

  iim_pkg::state_t   state_r, state_nxt;
  iim_pkg::mem_req_t req;
  logic [DW-1:0]     rd_data;

  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, ptr_r, ptr_nxt, pass_r, pass_nxt;
  logic          drop_r, drop_nxt, ovf_r, ovf_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [KW-1:0] best_r, best_nxt, prev_r, prev_nxt;
  logic          best_v_r, best_v_nxt, last_pend_r, last_pend_nxt;
  logic [31:0]   cur_s_r, cur_s_nxt, cur_e_r, cur_e_nxt;
  logic          out_v_r, out_v_nxt, out_l_r, out_l_nxt;
  logic [31:0]   out_s_r, out_s_nxt, out_e_r, out_e_nxt;

  logic          in_acc, out_acc, full;
  logic [KW-1:0] cand;
  logic [31:0]   bs, be, ns_e;

  iim_store u_store (.clk(clk), .req(req), .rd_data(rd_data));

  assign in_ready          = (state_r == iim_pkg::ST_LOAD);
  assign out_valid         = out_v_r;
  assign out_merged_start  = out_s_r;
  assign out_merged_end    = out_e_r;
  assign out_run_last      = out_l_r;
  assign out_overflow_seen = ovf_r;

  assign in_acc = in_valid & in_ready;
  assign out_acc = out_v_r & out_ready;
  assign full = (cnt_r == CW'(iim_pkg::STORE_DEPTH));
  assign cand = {rd_data, rd_idx_r};
  assign bs = best_r[KW-1 -: 32];
  assign be = best_r[KW-33 -: 32];

  always_comb begin
    req.wr_en   = in_acc & ~full;
    req.wr_addr = cnt_r[AW-1:0];
    req.wr_data = {in_range_start, in_range_end};
    req.rd_en   = (state_r == iim_pkg::ST_SCAN) && (ptr_r < n_r);
    req.rd_addr = ptr_r[AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; drop_nxt = drop_r; ovf_nxt = ovf_r; n_nxt = n_r;
    ptr_nxt = ptr_r; pass_nxt = pass_r;
    rd_v_nxt = 1'b0; rd_idx_nxt = ptr_r[AW-1:0];
    best_nxt = best_r; best_v_nxt = best_v_r; prev_nxt = prev_r;
    last_pend_nxt = last_pend_r;
    cur_s_nxt = cur_s_r; cur_e_nxt = cur_e_r;
    out_v_nxt = out_v_r; out_l_nxt = out_l_r; out_s_nxt = out_s_r; out_e_nxt = out_e_r;
    ns_e = cur_e_r;
    unique case (state_r)
      iim_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_final_item) begin
            state_nxt = iim_pkg::ST_SCAN;
            n_nxt = full ? cnt_r : cnt_r + CW'(1);
            ovf_nxt = full | drop_r;
            ptr_nxt = '0; pass_nxt = '0; best_v_nxt = 1'b0;
          end
        end
      end
      iim_pkg::ST_SCAN: begin
        if (ptr_r < n_r) begin
          ptr_nxt = ptr_r + CW'(1);
          rd_v_nxt = 1'b1;
        end
        if (rd_v_r && (pass_r == '0 || cand > prev_r) && (!best_v_r || cand < best_r)) begin
          best_nxt = cand;
          best_v_nxt = 1'b1;
        end
        if (ptr_r == n_r && !rd_v_r) begin
          prev_nxt = best_r;
          pass_nxt = pass_r + CW'(1);
          last_pend_nxt = (pass_r + CW'(1) == n_r);
          ptr_nxt = '0;
          best_v_nxt = 1'b0;
          if (pass_r == '0) begin
            cur_s_nxt = bs; cur_e_nxt = be;
          end else if (bs <= cur_e_r) begin
            ns_e = (be > cur_e_r) ? be : cur_e_r;
            cur_e_nxt = ns_e;
          end else begin
            out_v_nxt = 1'b1; out_l_nxt = 1'b0;
            out_s_nxt = cur_s_r; out_e_nxt = cur_e_r;
            cur_s_nxt = bs; cur_e_nxt = be;
            state_nxt = iim_pkg::ST_EMIT;
          end
          if (state_nxt == iim_pkg::ST_SCAN && pass_r + CW'(1) == n_r) begin
            out_v_nxt = 1'b1; out_l_nxt = 1'b1;
            out_s_nxt = cur_s_nxt; out_e_nxt = cur_e_nxt;
            state_nxt = iim_pkg::ST_EMIT;
          end
        end
      end
      iim_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (out_l_r) begin
            out_v_nxt = 1'b0;
            cnt_nxt = '0; drop_nxt = 1'b0;
            state_nxt = iim_pkg::ST_LOAD;
          end else if (last_pend_r) begin
            out_l_nxt = 1'b1;
            out_s_nxt = cur_s_r; out_e_nxt = cur_e_r;
          end else begin
            out_v_nxt = 1'b0;
            state_nxt = iim_pkg::ST_SCAN;
          end
        end
      end
      default: state_nxt = iim_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iim_pkg::ST_LOAD;
      cnt_r <= '0; drop_r <= 1'b0; rd_v_r <= 1'b0; out_v_r <= 1'b0;
      best_v_r <= 1'b0; pass_r <= '0; ptr_r <= '0; n_r <= '0;
      last_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt; drop_r <= drop_nxt; rd_v_r <= rd_v_nxt; out_v_r <= out_v_nxt;
      best_v_r <= best_v_nxt; pass_r <= pass_nxt; ptr_r <= ptr_nxt; n_r <= n_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt; rd_idx_r <= rd_idx_nxt;
    best_r <= best_nxt; prev_r <= prev_nxt;
    cur_s_r <= cur_s_nxt; cur_e_r <= cur_e_nxt;
    out_l_r <= out_l_nxt; out_s_r <= out_s_nxt; out_e_r <= out_e_nxt;
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(iim_pkg::STORE_DEPTH)) else $error("store count overrun");
  a_rd_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r) == iim_pkg::ST_SCAN) else $error("stray read");
  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_l_r) |=> (cnt_r == '0 && !drop_r)) else $error("set not cleared");
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == iim_pkg::ST_SCAN |-> pass_r < n_r) else $error("extra scan pass");
`endif
endmodule
